// ----- hw/rtl/vrgp_pkg.sv -----
`default_nettype none

package vrgp_pkg;

    // Phase accumulator width and the step register width; writes load only its low 24 bits.
    localparam int PHASE_BITS = 29;
    localparam int STEP_W     = 25;
    localparam int LEN_W      = 13;
    localparam int GAIN_W     = 16;
    localparam int SAMPLE_W   = 16;
    localparam int WORD_W     = 32;

    // Queue between the front and back parts.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Configuration port geometry.
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    // Input action codes.
    typedef enum logic [1:0] {
        ACT_WRITE = 2'd0,
        ACT_FRAME = 2'd1,
        ACT_START = 2'd2,
        ACT_STOP  = 2'd3
    } action_t;

    // Register indexes on the configuration port.
    typedef enum logic [2:0] {
        REG_STEP   = 3'd0,
        REG_LEN    = 3'd1,
        REG_MONO   = 3'd2,
        REG_LOOP   = 3'd3,
        REG_QUEUED = 3'd4,
        REG_LGAIN  = 3'd5,
        REG_RGAIN  = 3'd6
    } reg_idx_t;

    // Live configuration as seen by the datapath.
    typedef struct packed {
        logic [STEP_W-1:0] step;
        logic [LEN_W-1:0]  buffer_length;
        logic              mono;
        logic              loop_en;
        logic              queued;
        logic [GAIN_W-1:0] left_gain;
        logic [GAIN_W-1:0] right_gain;
    } cfg_t;

    // Per-transaction status decided by the front part.
    typedef struct packed {
        logic frame_valid;
        logic buffer_end;
        logic playing_now;
    } meta_t;

    // One queue entry: status plus the raw sample word.
    typedef struct packed {
        meta_t             meta;
        logic [WORD_W-1:0] word;
    } q_entry_t;

endpackage

`default_nettype wire

// ----- hw/rtl/vrgp_front.sv -----
`default_nettype none

module vrgp_front #(
    parameter int SAMPLE_DEPTH = 4096,
    parameter int FRAC_BITS    = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire vrgp_pkg::cfg_t    cfg,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [1:0]        action,
    input  wire logic [11:0]       sample_address,
    input  wire logic [31:0]       sample_word,
    input  wire logic [vrgp_pkg::QCNT_W-1:0] q_count,
    output logic                   push,
    output vrgp_pkg::q_entry_t     push_entry
);
    import vrgp_pkg::*;

    localparam int ADDR_W = $clog2(SAMPLE_DEPTH);
    localparam int IDX_W  = PHASE_BITS - FRAC_BITS;

    logic [PHASE_BITS-1:0] phase_reg, phase_next;
    logic                  playing_reg, playing_next;
    logic                  s1_valid_reg;
    meta_t                 s1_meta_reg, meta_next;
    logic [WORD_W-1:0]     rd_data_reg;
    logic [WORD_W-1:0]     store_mem [SAMPLE_DEPTH];

    logic                  accept;
    logic                  wr_en, rd_en;
    logic [ADDR_W-1:0]     wr_addr, rd_addr;
    logic [IDX_W-1:0]      idx;
    logic [31:0]           idx_ext, len_ext, len_eff, addr_ext;

    // Hold off new transactions while the queue could not take what is in flight.
    assign in_stall = (4'(q_count) + 4'(s1_valid_reg)) >= 4'(QDEPTH);
    assign accept   = in_valid && !in_stall;

    assign idx      = phase_reg[PHASE_BITS-1:FRAC_BITS];
    assign idx_ext  = 32'(idx);
    assign len_ext  = 32'(cfg.buffer_length);
    assign len_eff  = (len_ext > 32'(SAMPLE_DEPTH)) ? 32'(SAMPLE_DEPTH) : len_ext;
    assign addr_ext = 32'(sample_address);
    assign wr_addr  = ADDR_W'(addr_ext);
    assign rd_addr  = ADDR_W'(idx_ext);

    // Classify the transaction and update phase and playing state.
    always_comb
    begin
        phase_next   = phase_reg;
        playing_next = playing_reg;
        wr_en        = 1'b0;
        rd_en        = 1'b0;
        meta_next    = '0;
        if (accept)
        begin
            case (action_t'(action))
                ACT_WRITE:
                begin
                    wr_en = addr_ext < 32'(SAMPLE_DEPTH);
                end
                ACT_FRAME:
                begin
                    if (playing_reg)
                    begin
                        if (idx_ext >= len_eff)
                        begin
                            // Buffer end: rewind and give no frame.
                            phase_next = '0;
                            if (cfg.queued)
                            begin
                                meta_next.buffer_end = 1'b1;
                            end
                            else if (!cfg.loop_en)
                            begin
                                playing_next = 1'b0;
                            end
                        end
                        else
                        begin
                            rd_en                 = 1'b1;
                            meta_next.frame_valid = 1'b1;
                            phase_next            = phase_reg + PHASE_BITS'(cfg.step);
                        end
                    end
                end
                ACT_START:
                begin
                    phase_next   = '0;
                    playing_next = 1'b1;
                end
                ACT_STOP:
                begin
                    phase_next   = '0;
                    playing_next = 1'b0;
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
        meta_next.playing_now = playing_next;
    end

    // Control state and the first pipeline stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= '0;
            playing_reg  <= 1'b0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            playing_reg  <= playing_next;
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_meta_reg <= meta_next;
        end
    end

    // Sample store with one write port and a registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= sample_word;
        end
        if (rd_en)
        begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    assign push            = s1_valid_reg;
    assign push_entry.meta = s1_meta_reg;
    assign push_entry.word = rd_data_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/vrgp_queue.sv -----
`default_nettype none

module vrgp_queue (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         push,
    input  wire vrgp_pkg::q_entry_t           push_entry,
    input  wire logic                         pop,
    output vrgp_pkg::q_entry_t                head_entry,
    output logic                              nonempty,
    output logic [vrgp_pkg::QCNT_W-1:0]       count
);
    import vrgp_pkg::*;

    q_entry_t           entry_reg [QDEPTH];
    logic [QPTR_W-1:0]  wptr_reg, wptr_next;
    logic [QPTR_W-1:0]  rptr_reg, rptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;

    assign head_entry = entry_reg[rptr_reg];
    assign nonempty   = count_reg != '0;
    assign count      = count_reg;

    // Pointer and fill count update.
    always_comb
    begin
        wptr_next  = push ? wptr_reg + 1'b1 : wptr_reg;
        rptr_next  = pop ? rptr_reg + 1'b1 : rptr_reg;
        count_next = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wptr_reg] <= push_entry;
        end
    end

    // The front must never push into a full queue.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |-> count_reg < QCNT_W'(QDEPTH))
        else $error("queue push while full");

    // The back must never pop an empty queue.
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("queue pop while empty");

    // Fill count tracks the pointer distance.
    a_count_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        QPTR_W'(count_reg) == QPTR_W'(wptr_reg - rptr_reg))
        else $error("queue count and pointers disagree");

endmodule

`default_nettype wire

// ----- hw/rtl/vrgp_back.sv -----
`default_nettype none

module vrgp_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire vrgp_pkg::cfg_t      cfg,
    input  wire vrgp_pkg::q_entry_t  head_entry,
    input  wire logic                nonempty,
    output logic                     pop,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic [31:0]              frame_word,
    output logic                     frame_valid,
    output logic                     buffer_end,
    output logic                     playing_now
);
    import vrgp_pkg::*;

    logic                      advance;
    logic                      b1_valid_reg;
    meta_t                     b1_meta_reg;
    logic signed [32:0]        prod_l_reg, prod_r_reg;
    logic signed [32:0]        prod_l_next, prod_r_next;
    logic signed [32:0]        bias_l, bias_r;
    logic [SAMPLE_W-1:0]       lo, hi;
    logic                      out_valid_reg;
    meta_t                     out_meta_reg;
    logic [WORD_W-1:0]         out_word_reg, out_word_next;

    // The pipeline moves whenever the output register is free or being taken.
    assign advance = !out_valid_reg || !out_stall;
    assign pop     = nonempty && advance;

    // Select channel samples and form the gain products.
    always_comb
    begin
        lo          = head_entry.word[SAMPLE_W-1:0];
        hi          = cfg.mono ? lo : head_entry.word[WORD_W-1:SAMPLE_W];
        prod_l_next = $signed(lo) * $signed({1'b0, cfg.left_gain});
        prod_r_next = $signed(hi) * $signed({1'b0, cfg.right_gain});
    end

    // Truncate toward zero by biasing negative products before the shift.
    always_comb
    begin
        bias_l = prod_l_reg + (prod_l_reg[32] ? 33'sd32767 : 33'sd0);
        bias_r = prod_r_reg + (prod_r_reg[32] ? 33'sd32767 : 33'sd0);
        out_word_next = b1_meta_reg.frame_valid ? {bias_r[30:15], bias_l[30:15]} : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            b1_valid_reg  <= pop;
            out_valid_reg <= b1_valid_reg;
        end
    end

    // Product stage and output register.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            b1_meta_reg  <= head_entry.meta;
            prod_l_reg   <= prod_l_next;
            prod_r_reg   <= prod_r_next;
            out_meta_reg <= b1_meta_reg;
            out_word_reg <= out_word_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign frame_word  = out_word_reg;
    assign frame_valid = out_meta_reg.frame_valid;
    assign buffer_end  = out_meta_reg.buffer_end;
    assign playing_now = out_meta_reg.playing_now;

endmodule

`default_nettype wire

// ----- hw/rtl/voice_resample_gain_packer_top.sv -----
// Single-voice sample player with nearest-neighbor rate conversion.
// Input channel (in_valid/in_stall): each transaction carries an action:
// write a sample word into the store, request a frame, start, or stop.
// Every accepted transaction yields exactly one result transaction on the
// output channel (out_valid/out_stall) with frame_word, frame_valid,
// buffer_end and playing_now.
// Configuration lives behind the APB-style port; write it only while the
// block is idle. pready is always high.
// Path: an accepted transaction passes the front decode and store read
// register, then the queue, the gain multiplier register and the output
// register.
// Throughput: one transaction per cycle while in_stall is low, set by the
// single phase add and the one-port store read that each frame request needs.
// When the receiver stalls, the output register holds its result and the
// 4-entry queue between front and back absorbs in-flight work; in_stall
// rises once the queue cannot take more.
// Reset clears phase, the playing flag, all pipeline valids and restores
// the register defaults. The sample store is not cleared.
`default_nettype none

module voice_resample_gain_packer_top #(
    parameter int SAMPLE_DEPTH = 4096,
    parameter int FRAC_BITS    = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [vrgp_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [vrgp_pkg::PDATA_W-1:0]  pwdata,
    output logic [vrgp_pkg::PDATA_W-1:0]       prdata,
    output logic                               pready,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [1:0]                    action,
    input  wire logic [11:0]                   sample_address,
    input  wire logic [31:0]                   sample_word,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [31:0]                        frame_word,
    output logic                               frame_valid,
    output logic                               buffer_end,
    output logic                               playing_now
);
    import vrgp_pkg::*;

    logic [STEP_W-1:0] step_reg;
    logic [LEN_W-1:0]  len_reg;
    logic              mono_reg;
    logic              loop_reg;
    logic              queued_reg;
    logic [GAIN_W-1:0] lgain_reg;
    logic [GAIN_W-1:0] rgain_reg;
    logic              cfg_wr;
    reg_idx_t          reg_idx;
    cfg_t              cfg;

    logic              push, pop, nonempty;
    q_entry_t          push_entry, head_entry;
    logic [QCNT_W-1:0] q_count;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = reg_idx_t'(paddr[4:2]);

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg   <= STEP_W'(1) << FRAC_BITS;
            len_reg    <= LEN_W'(4096);
            mono_reg   <= 1'b0;
            loop_reg   <= 1'b0;
            queued_reg <= 1'b0;
            lgain_reg  <= GAIN_W'(32768);
            rgain_reg  <= GAIN_W'(32768);
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                REG_STEP:   step_reg   <= STEP_W'(pwdata[23:0]);
                REG_LEN:    len_reg    <= pwdata[LEN_W-1:0];
                REG_MONO:   mono_reg   <= pwdata[0];
                REG_LOOP:   loop_reg   <= pwdata[0];
                REG_QUEUED: queued_reg <= pwdata[0];
                REG_LGAIN:  lgain_reg  <= pwdata[GAIN_W-1:0];
                REG_RGAIN:  rgain_reg  <= pwdata[GAIN_W-1:0];
                default:    step_reg   <= step_reg;
            endcase
        end
    end

    // Register read-back.
    always_comb
    begin
        case (reg_idx)
            REG_STEP:   prdata = PDATA_W'(step_reg);
            REG_LEN:    prdata = PDATA_W'(len_reg);
            REG_MONO:   prdata = PDATA_W'(mono_reg);
            REG_LOOP:   prdata = PDATA_W'(loop_reg);
            REG_QUEUED: prdata = PDATA_W'(queued_reg);
            REG_LGAIN:  prdata = PDATA_W'(lgain_reg);
            REG_RGAIN:  prdata = PDATA_W'(rgain_reg);
            default:    prdata = '0;
        endcase
    end

    assign cfg.step          = step_reg;
    assign cfg.buffer_length = len_reg;
    assign cfg.mono          = mono_reg;
    assign cfg.loop_en       = loop_reg;
    assign cfg.queued        = queued_reg;
    assign cfg.left_gain     = lgain_reg;
    assign cfg.right_gain    = rgain_reg;

    vrgp_front #(
        .SAMPLE_DEPTH (SAMPLE_DEPTH),
        .FRAC_BITS    (FRAC_BITS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .action         (action),
        .sample_address (sample_address),
        .sample_word    (sample_word),
        .q_count        (q_count),
        .push           (push),
        .push_entry     (push_entry)
    );

    vrgp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head_entry (head_entry),
        .nonempty   (nonempty),
        .count      (q_count)
    );

    vrgp_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .head_entry  (head_entry),
        .nonempty    (nonempty),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .frame_word  (frame_word),
        .frame_valid (frame_valid),
        .buffer_end  (buffer_end),
        .playing_now (playing_now)
    );

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;

    import vrgp_pkg::*;

    localparam int SAMPLE_DEPTH = 4096;
    localparam int FRAC_BITS    = 16;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_COUNT  = 8;
    localparam int PHASE_ITEMS  = 60;
    localparam int LONG_HOLD    = 300;

    // Expected contents of one output transaction.
    typedef struct packed {
        logic [31:0] frame_word;
        logic        frame_valid;
        logic        buffer_end;
        logic        playing_now;
    } frame_result_t;

    // Predicts the voice player and checks its output transactions in order.
    class voice_frame_predictor;
        logic [31:0]   store_words [SAMPLE_DEPTH];
        bit            store_filled [SAMPLE_DEPTH];
        bit [28:0]     phase;
        bit            playing;
        bit [23:0]     step_inc;
        bit [12:0]     buf_len;
        bit            mono;
        bit            loop_en;
        bit            queued;
        bit [15:0]     gain_l;
        bit [15:0]     gain_r;
        frame_result_t pending_frames [$];
        int            mismatches;

        function new();
            phase      = '0;
            playing    = 1'b0;
            step_inc   = 24'h01_0000;
            buf_len    = 13'd4096;
            mono       = 1'b0;
            loop_en    = 1'b0;
            queued     = 1'b0;
            gain_l     = 16'h8000;
            gain_r     = 16'h8000;
            mismatches = 0;
            foreach (store_filled[i]) store_filled[i] = 1'b0;
        endfunction

        function void set_register(reg_idx_t idx, logic [31:0] value);
            case (idx)
                REG_STEP:   step_inc = value[23:0];
                REG_LEN:    buf_len  = value[12:0];
                REG_MONO:   mono     = value[0];
                REG_LOOP:   loop_en  = value[0];
                REG_QUEUED: queued   = value[0];
                REG_LGAIN:  gain_l   = value[15:0];
                REG_RGAIN:  gain_r   = value[15:0];
                default:    ;
            endcase
        endfunction

        function int effective_length();
            if (buf_len > 13'(SAMPLE_DEPTH))
                return SAMPLE_DEPTH;
            return int'(buf_len);
        endfunction

        // True when the next frame request would read an entry never written.
        function bit needs_fill(output int idx);
            idx = int'(phase >> FRAC_BITS);
            return playing && (idx < effective_length()) && !store_filled[idx];
        endfunction

        // Signed sample times unsigned Q1.15 gain, truncated toward zero.
        function logic [15:0] apply_gain(logic [15:0] raw, logic [15:0] gain);
            longint s;
            longint g;
            longint p;
            s = longint'($signed(raw));
            g = longint'(gain);
            p = (s * g) / 32768;
            return p[15:0];
        endfunction

        function void note_transaction(action_t act, logic [11:0] addr, logic [31:0] word);
            frame_result_t res;
            int            idx;
            logic [31:0]   w;
            logic [15:0]   lo;
            logic [15:0]   hi;
            res = '0;
            case (act)
                ACT_WRITE:
                begin
                    store_words[addr]  = word;
                    store_filled[addr] = 1'b1;
                end
                ACT_FRAME:
                begin
                    if (playing)
                    begin
                        idx = int'(phase >> FRAC_BITS);
                        if (idx >= effective_length())
                        begin
                            // Buffer end: rewind and give no frame.
                            phase = '0;
                            if (queued)
                                res.buffer_end = 1'b1;
                            else if (!loop_en)
                                playing = 1'b0;
                        end
                        else
                        begin
                            w  = store_words[idx];
                            lo = w[15:0];
                            hi = mono ? lo : w[31:16];
                            res.frame_word  = {apply_gain(hi, gain_r), apply_gain(lo, gain_l)};
                            res.frame_valid = 1'b1;
                            phase = phase + 29'(step_inc);
                        end
                    end
                end
                ACT_START:
                begin
                    if (playing)
                        phase = '0;
                    playing = 1'b1;
                end
                default:
                begin
                    playing = 1'b0;
                    phase   = '0;
                end
            endcase
            res.playing_now = playing;
            pending_frames.push_back(res);
        endfunction

        function void check_result(logic [31:0] fw, logic fv, logic be, logic pn);
            frame_result_t exp_res;
            if (pending_frames.size() == 0)
            begin
                $error("result transaction with no input pending: frame_word %h", fw);
                mismatches++;
                return;
            end
            exp_res = pending_frames.pop_front();
            if (fw !== exp_res.frame_word)
            begin
                $error("frame_word: expected %h, got %h", exp_res.frame_word, fw);
                mismatches++;
            end
            if (fv !== exp_res.frame_valid)
            begin
                $error("frame_valid: expected %b, got %b", exp_res.frame_valid, fv);
                mismatches++;
            end
            if (be !== exp_res.buffer_end)
            begin
                $error("buffer_end: expected %b, got %b", exp_res.buffer_end, be);
                mismatches++;
            end
            if (pn !== exp_res.playing_now)
            begin
                $error("playing_now: expected %b, got %b", exp_res.playing_now, pn);
                mismatches++;
            end
        endfunction

        function int outstanding();
            return pending_frames.size();
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;
    logic                in_valid;
    logic                in_stall;
    logic [1:0]          action;
    logic [11:0]         sample_address;
    logic [31:0]         sample_word;
    logic                out_valid;
    logic                out_stall;
    logic [31:0]         frame_word;
    logic                frame_valid;
    logic                buffer_end;
    logic                playing_now;

    voice_frame_predictor frames;
    bit                   calm_phase;
    bit                   hold_output_req;
    int                   cycle_count;

    voice_resample_gain_packer_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .action         (action),
        .sample_address (sample_address),
        .sample_word    (sample_word),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .frame_word     (frame_word),
        .frame_valid    (frame_valid),
        .buffer_end     (buffer_end),
        .playing_now    (playing_now)
    );

    always #5 clk = ~clk;

    // Run limit.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("status: fail");
        $finish;
    end

    // Check every accepted output transaction.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            frames.check_result(frame_word, frame_valid, buffer_end, playing_now);
    end

    // Output stall: random bursts, free stretches, and one long hold-off on request.
    initial
    begin
        out_stall = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (hold_output_req)
            begin
                hold_output_req = 1'b0;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge clk);
            end
            else if (!calm_phase && $urandom_range(0, 2) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 12)) @(negedge clk);
            end
            else
            begin
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 30)) @(negedge clk);
            end
        end
    end

    // Offer one input transaction and wait until it is taken.
    task automatic send_item(input action_t act, input logic [11:0] addr,
                             input logic [31:0] word);
        if (!calm_phase && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
        in_valid       <= 1'b1;
        action         <= act;
        sample_address <= addr;
        sample_word    <= word;
        do
            @(posedge clk);
        while (in_stall);
        frames.note_transaction(act, addr, word);
        @(negedge clk);
    endtask

    // Control actions carry random payload that the block ignores.
    task automatic send_control(input action_t act);
        send_item(act, 12'($urandom_range(0, 4095)), $urandom());
    endtask

    // Frame request; an unwritten entry under the phase is written first.
    task automatic request_frame();
        int idx;
        if (frames.needs_fill(idx))
            send_item(ACT_WRITE, 12'(idx), $urandom());
        send_control(ACT_FRAME);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (frames.outstanding() != 0)
            @(negedge clk);
        @(negedge clk);
    endtask

    task automatic write_register(input reg_idx_t idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        frames.set_register(idx, value);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    // Writes every register; low and high flavors pin the extremes.
    task automatic apply_settings(input int flavor);
        logic [31:0] step_val;
        logic [31:0] len_val;
        logic [31:0] lgain_val;
        logic [31:0] rgain_val;
        int          pick;
        wait_drained();
        repeat (8) @(negedge clk);
        pick = $urandom_range(0, 19);
        case (flavor)
            1:
            begin
                step_val  = 32'd0;
                len_val   = 32'd1;
                lgain_val = 32'd0;
                rgain_val = 32'd0;
            end
            2:
            begin
                step_val  = 32'hFF_FFFF;
                len_val   = 32'h1FFF;
                lgain_val = 32'hFFFF;
                rgain_val = 32'hFFFF;
            end
            default:
            begin
                step_val  = $urandom_range(32'h2000, 32'h3_0000);
                if (pick < 13)
                    len_val = $urandom_range(1, 24);
                else if (pick < 15)
                    len_val = 32'd4096;
                else if (pick < 17)
                    len_val = $urandom_range(100, 4095);
                else if (pick < 18)
                    len_val = 32'd0;
                else
                    len_val = $urandom_range(4097, 8191);
                lgain_val = $urandom_range(0, 65535);
                rgain_val = $urandom_range(0, 65535);
            end
        endcase
        write_register(REG_STEP, step_val);
        write_register(REG_LEN, len_val);
        write_register(REG_MONO, 32'($urandom_range(0, 1)));
        write_register(REG_LOOP, 32'($urandom_range(0, 1)));
        write_register(REG_QUEUED, 32'($urandom_range(0, 1)));
        write_register(REG_LGAIN, lgain_val);
        write_register(REG_RGAIN, rgain_val);
    endtask

    // One random transaction, weighted toward playback while playing.
    task automatic random_item();
        int pick;
        int span;
        pick = $urandom_range(0, 99);
        if (!frames.playing && pick < 60 && $urandom_range(0, 1) == 1)
            pick = 85;
        if (pick < 60)
            request_frame();
        else if (pick < 82)
        begin
            span = frames.effective_length();
            if (span > 0 && $urandom_range(0, 1) == 1)
                send_item(ACT_WRITE, 12'($urandom_range(0, span - 1)), $urandom());
            else
                send_item(ACT_WRITE, 12'($urandom_range(0, 4095)), $urandom());
        end
        else if (pick < 94)
            send_control(ACT_START);
        else
            send_control(ACT_STOP);
    endtask

    initial
    begin
        frames          = new();
        calm_phase      = 1'b0;
        hold_output_req = 1'b0;
        rst_n           = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        in_valid        = 1'b0;
        action          = ACT_WRITE;
        sample_address  = '0;
        sample_word     = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Reset settings: stopped request, sample extremes, start, rewind, stop.
        request_frame();
        send_item(ACT_WRITE, 12'd0, 32'h7FFF_8000);
        send_item(ACT_WRITE, 12'd1, 32'hFFFF_0001);
        send_item(ACT_WRITE, 12'd2, 32'h8000_7FFF);
        send_item(ACT_WRITE, 12'd3, 32'h0000_0000);
        send_item(ACT_WRITE, 12'hFFF, 32'hFFFF_FFFF);
        send_control(ACT_START);
        repeat (3) request_frame();
        send_control(ACT_START);
        request_frame();
        send_control(ACT_STOP);
        request_frame();

        // Short buffer in mono with full and zero gain: plays out, then stops.
        wait_drained();
        repeat (8) @(negedge clk);
        write_register(REG_LEN, 32'd3);
        write_register(REG_MONO, 32'd1);
        write_register(REG_LGAIN, 32'hFFFF);
        write_register(REG_RGAIN, 32'd0);
        send_control(ACT_START);
        repeat (5) request_frame();

        // Zero length in queued mode: every request flags buffer end.
        wait_drained();
        repeat (8) @(negedge clk);
        write_register(REG_LEN, 32'd0);
        write_register(REG_QUEUED, 32'd1);
        send_control(ACT_START);
        repeat (2) request_frame();

        // Random phases, each with its own settings.
        for (int ph = 0; ph < PHASE_COUNT; ph++)
        begin
            apply_settings(ph == 0 ? 2 : (ph == 1 ? 1 : 0));
            if (ph == PHASE_COUNT - 1)
                calm_phase = 1'b1;
            send_control(ACT_START);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (ph == 3 && n == 10)
                    hold_output_req = 1'b1;
                if (ph == 4 && n == 20)
                    wait_drained();
                random_item();
            end
        end

        // Drain and let the pipeline settle.
        wait_drained();
        repeat (10) @(negedge clk);
        if (frames.mismatches == 0 && frames.outstanding() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
